FILE: design/sspct_pkg.sv
`default_nettype none
package sspct_pkg;

   localparam int COORD_WIDTH    = 24;
   localparam int TIME_FRAC_BITS = 16;

   localparam int CW   = COORD_WIDTH;
   localparam int RW   = COORD_WIDTH - 2;   // radius width
   localparam int TW   = TIME_FRAC_BITS + 1; // contact time width
   localparam int SW   = 2 * CW;            // squares and dot magnitude
   localparam int PW   = SW + 2;            // signed dot sum
   localparam int WW   = 4 * CW;            // b*b and a*c
   localparam int RSQW = SW + 2;            // (R + m)^2
   localparam int TOLW = 16;

   localparam int REQ_DATA_W = ((6 * CW + 2 * RW + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((TW + 7) / 8) * 8;
   localparam int RSP_USER_W = 4;

   // stage map of the iterative part of the pipeline
   localparam int REACH_STG = CW + 1;
   localparam int CHECK_STG = CW + 2;
   localparam int SQ2_FIRST = CW + 3;
   localparam int NUM_STG   = CW + 3 + SW;
   localparam int DIV_FIRST = NUM_STG + 1;
   localparam int LAST_STG  = NUM_STG + TIME_FRAC_BITS;
   localparam int NSTG      = LAST_STG + 1;

   typedef enum logic [2:0] {
      OUT_HIT       = 3'd0,
      OUT_NO_MOTION = 3'd1,
      OUT_OVERLAP   = 3'd2,
      OUT_SEPARATE  = 3'd3,
      OUT_UNREACH   = 3'd4,
      OUT_MISS      = 3'd5
   } outcome_type;

   typedef struct packed {
      outcome_type               code;
      logic                      sat;
      logic [SW-1:0]             vsq;
      logic [SW-1:0]             dsq;
      logic [RW:0]               rsum;
      logic [SW-1:0]             babs;
      logic [WW-1:0]             b2;
      logic [WW-1:0]             ac;
      logic [WW-1:0]             rem;
      logic [SW-1:0]             root;
      logic [TIME_FRAC_BITS-1:0] quo;
   } pipe_type;

endpackage
`default_nettype wire

FILE: design/swept_sphere_pair_contact_time_core.sv
`default_nettype none
// Throughput: one transaction per cycle while the rsp side is not stalled;
// the chain of a 24-step square root of v.v, a 48-step square root of the
// discriminant and a 16-step divider sets the depth.
// Reset: clears all stage valid bits and loads motion_tolerance with 4.
// A stalled rsp side holds the whole pipeline in place; nothing is lost.
module swept_sphere_pair_contact_time_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [sspct_pkg::TOLW-1:0]         csr_write_data,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // center_offset_x/y/z, relative_motion_x/y/z, focus_radius, target_radius, zero pad
   input  wire logic [sspct_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // contact_time, zero pad
   output logic [sspct_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // hit, outcome
   output logic [sspct_pkg::RSP_USER_W-1:0]        rsp_tuser
);
   import sspct_pkg::*;

   logic [TOLW-1:0] tol_ff;
   logic            adv;

   // stage A: unpack
   logic                 a_valid_ff;
   logic signed [CW-1:0] a_d_ff [3];
   logic signed [CW-1:0] a_v_ff [3];
   logic [RW:0]          a_rsum_ff;

   // stage B: products
   logic                 b_valid_ff;
   logic signed [SW-1:0] b_vv_ff [3];
   logic signed [SW-1:0] b_dd_ff [3];
   logic signed [SW-1:0] b_dv_ff [3];
   logic [SW-3:0]        b_rsq_ff;
   logic [2*TOLW-1:0]    b_tolsq_ff;
   logic [RW:0]          b_rsum_ff;

   // stage C: sums
   logic                 c_valid_ff;
   logic [SW-1:0]        c_vsq_ff, c_dsq_ff;
   logic signed [PW-1:0] c_dot_ff;
   logic [SW-3:0]        c_rsq_ff;
   logic [2*TOLW-1:0]    c_tolsq_ff;
   logic [RW:0]          c_rsum_ff;

   // stage D: early rejections
   logic          d_valid_ff;
   outcome_type   d_code_ff;
   logic [SW-1:0] d_vsq_ff, d_dsq_ff, d_babs_ff, d_dmr_ff;
   logic [RW:0]   d_rsum_ff;

   // stage E: partial products of b*b and a*c
   logic          e_valid_ff;
   outcome_type   e_code_ff;
   logic [SW-1:0] e_vsq_ff, e_dsq_ff, e_babs_ff;
   logic [RW:0]   e_rsum_ff;
   logic [SW-1:0] e_bhh_ff, e_bhl_ff, e_bll_ff;
   logic [SW-1:0] e_chh_ff, e_chl_ff, e_clh_ff, e_cll_ff;

   // stage F: full products
   logic          f_valid_ff;
   outcome_type   f_code_ff;
   logic [SW-1:0] f_vsq_ff, f_dsq_ff, f_babs_ff;
   logic [RW:0]   f_rsum_ff;
   logic [WW-1:0] f_b2_ff, f_ac_ff;

   // iterative stages
   logic     p_valid_ff [NSTG];
   pipe_type p_ff [NSTG];
   pipe_type p_in [NSTG];

   logic [TW-1:0] time_out;
   logic          hit_out;

   // advance everything unless the output holds an untaken result
   assign adv        = !p_valid_ff[LAST_STG] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOLW'(4);
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         for (int i = 0; i < NSTG; i++) p_valid_ff[i] <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         p_valid_ff[0] <= f_valid_ff;
         for (int i = 1; i < NSTG; i++) p_valid_ff[i] <= p_valid_ff[i-1];
      end
   end

   // payload of the fixed front stages
   always_ff @(posedge clock) begin
      if (adv) begin
         // A: unpack the transaction
         for (int i = 0; i < 3; i++) begin
            a_d_ff[i] <= req_tdata[i*CW +: CW];
            a_v_ff[i] <= req_tdata[(3+i)*CW +: CW];
         end
         a_rsum_ff <= {1'b0, req_tdata[6*CW +: RW]} + {1'b0, req_tdata[6*CW+RW +: RW]};

         // B: one multiplier per product
         for (int i = 0; i < 3; i++) begin
            b_vv_ff[i] <= a_v_ff[i] * a_v_ff[i];
            b_dd_ff[i] <= a_d_ff[i] * a_d_ff[i];
            b_dv_ff[i] <= a_d_ff[i] * a_v_ff[i];
         end
         b_rsq_ff   <= (SW-2)'(a_rsum_ff) * (SW-2)'(a_rsum_ff);
         b_tolsq_ff <= (2*TOLW)'(tol_ff) * (2*TOLW)'(tol_ff);
         b_rsum_ff  <= a_rsum_ff;

         // C: dot products
         c_vsq_ff   <= SW'(b_vv_ff[0]) + SW'(b_vv_ff[1]) + SW'(b_vv_ff[2]);
         c_dsq_ff   <= SW'(b_dd_ff[0]) + SW'(b_dd_ff[1]) + SW'(b_dd_ff[2]);
         c_dot_ff   <= PW'(b_dv_ff[0]) + PW'(b_dv_ff[1]) + PW'(b_dv_ff[2]);
         c_rsq_ff   <= b_rsq_ff;
         c_tolsq_ff <= b_tolsq_ff;
         c_rsum_ff  <= b_rsum_ff;

         // D: first three rejections in priority order
         priority if (c_vsq_ff <= SW'(c_tolsq_ff)) d_code_ff <= OUT_NO_MOTION;
         else if (c_dsq_ff <= SW'(c_rsq_ff))       d_code_ff <= OUT_OVERLAP;
         else if (c_dot_ff >= 0)                   d_code_ff <= OUT_SEPARATE;
         else                                      d_code_ff <= OUT_HIT;
         d_babs_ff <= SW'(-c_dot_ff);
         d_dmr_ff  <= c_dsq_ff - SW'(c_rsq_ff);
         d_vsq_ff  <= c_vsq_ff;
         d_dsq_ff  <= c_dsq_ff;
         d_rsum_ff <= c_rsum_ff;

         // E: split the wide products into half-width partials
         e_bhh_ff  <= SW'(d_babs_ff[SW-1:CW]) * SW'(d_babs_ff[SW-1:CW]);
         e_bhl_ff  <= SW'(d_babs_ff[SW-1:CW]) * SW'(d_babs_ff[CW-1:0]);
         e_bll_ff  <= SW'(d_babs_ff[CW-1:0]) * SW'(d_babs_ff[CW-1:0]);
         e_chh_ff  <= SW'(d_vsq_ff[SW-1:CW]) * SW'(d_dmr_ff[SW-1:CW]);
         e_chl_ff  <= SW'(d_vsq_ff[SW-1:CW]) * SW'(d_dmr_ff[CW-1:0]);
         e_clh_ff  <= SW'(d_vsq_ff[CW-1:0]) * SW'(d_dmr_ff[SW-1:CW]);
         e_cll_ff  <= SW'(d_vsq_ff[CW-1:0]) * SW'(d_dmr_ff[CW-1:0]);
         e_code_ff <= d_code_ff;
         e_vsq_ff  <= d_vsq_ff;
         e_dsq_ff  <= d_dsq_ff;
         e_babs_ff <= d_babs_ff;
         e_rsum_ff <= d_rsum_ff;

         // F: assemble b*b and a*c
         f_b2_ff <= (WW'(e_bhh_ff) << SW) + (WW'(e_bhl_ff) << (CW + 1)) + WW'(e_bll_ff);
         f_ac_ff <= (WW'(e_chh_ff) << SW) + (WW'(e_chl_ff) << CW)
                    + (WW'(e_clh_ff) << CW) + WW'(e_cll_ff);
         f_code_ff <= e_code_ff;
         f_vsq_ff  <= e_vsq_ff;
         f_dsq_ff  <= e_dsq_ff;
         f_babs_ff <= e_babs_ff;
         f_rsum_ff <= e_rsum_ff;
      end
   end

   // one square-root digit, reach, check, numerator or divider step per stage
   always_comb begin
      pipe_type      nxt;
      logic [WW-1:0] trial;
      logic [RW+2:0] reach;
      logic [RSQW-1:0] reach_sq;
      logic [SW:0]   rem2;
      logic [SW-1:0] num;
      int            k;
      for (int i = 0; i < NSTG; i++) begin
         trial    = '0;
         reach    = '0;
         reach_sq = '0;
         rem2     = '0;
         num      = '0;
         k        = 0;
         if (i == 0) begin
            nxt.code = f_code_ff;
            nxt.sat  = 1'b0;
            nxt.vsq  = f_vsq_ff;
            nxt.dsq  = f_dsq_ff;
            nxt.rsum = f_rsum_ff;
            nxt.babs = f_babs_ff;
            nxt.b2   = f_b2_ff;
            nxt.ac   = f_ac_ff;
            nxt.rem  = WW'(f_vsq_ff);
            nxt.root = '0;
            nxt.quo  = '0;
         end else begin
            nxt = p_ff[i-1];
            if (i < REACH_STG || (i >= SQ2_FIRST && i < NUM_STG)) begin
               // restoring square root, one result bit
               k = (i < REACH_STG) ? (CW - i) : (SW - 1 - (i - SQ2_FIRST));
               trial = (WW'(nxt.root) << (k + 1)) | (WW'(1) << (2 * k));
               if (trial <= nxt.rem) begin
                  nxt.rem  = nxt.rem - trial;
                  nxt.root = nxt.root | (SW'(1) << k);
               end
            end else if (i == REACH_STG) begin
               reach    = (RW+3)'(nxt.rsum) + (RW+3)'(nxt.root);
               reach_sq = RSQW'(reach) * RSQW'(reach);
               nxt.rem  = WW'(reach_sq);
            end else if (i == CHECK_STG) begin
               if (nxt.code == OUT_HIT) begin
                  priority if (RSQW'(nxt.dsq) > RSQW'(nxt.rem)) nxt.code = OUT_UNREACH;
                  else if (nxt.ac > nxt.b2)                     nxt.code = OUT_MISS;
                  else                                          nxt.code = OUT_HIT;
               end
               nxt.rem  = nxt.b2 - nxt.ac;
               nxt.root = '0;
            end else if (i == NUM_STG) begin
               num     = nxt.babs - nxt.root;
               nxt.sat = (num >= nxt.vsq);
               nxt.rem = WW'(num);
               nxt.quo = '0;
            end else begin
               // long division, one quotient bit
               rem2 = {nxt.rem[SW-1:0], 1'b0};
               if (rem2 >= {1'b0, nxt.vsq}) begin
                  nxt.rem = WW'(rem2 - {1'b0, nxt.vsq});
                  nxt.quo = {nxt.quo[TIME_FRAC_BITS-2:0], 1'b1};
               end else begin
                  nxt.rem = WW'(rem2);
                  nxt.quo = {nxt.quo[TIME_FRAC_BITS-2:0], 1'b0};
               end
            end
         end
         p_in[i] = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NSTG; i++) p_ff[i] <= p_in[i];
      end
   end

   // output: saturate at 1.0, zero time on any rejection
   assign hit_out  = (p_ff[LAST_STG].code == OUT_HIT);
   assign time_out = !hit_out ? '0 :
                     p_ff[LAST_STG].sat ? (TW'(1) << TIME_FRAC_BITS) :
                     {1'b0, p_ff[LAST_STG].quo};

   assign rsp_tvalid = p_valid_ff[LAST_STG];
   assign rsp_tdata  = RSP_DATA_W'(time_out);
   assign rsp_tuser  = {p_ff[LAST_STG].code, hit_out};

   // checks
   a_hit_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[3:1] == OUT_HIT)))
      else $error("hit flag disagrees with outcome");

   a_no_time_on_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("nonzero contact time on a rejection");

   a_accept_only_when_moving: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
      else $error("input taken while the pipeline is stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented right after reset");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sspct_pkg::*;

   localparam int IDLE_WAIT   = 120;    // pipeline depth plus margin
   localparam int STALL_LIMIT = 20000;  // cycles without any transaction
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off

   typedef logic [REQ_DATA_W-1:0] pair_word_type;

   typedef struct {
      logic             hit;
      logic [TW-1:0]    contact_time;
      outcome_type      outcome;
   } contact_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic            csr_write_enable = 1'b0;
   logic [TOLW-1:0] csr_write_data   = '0;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   // center_offset_x/y/z, relative_motion_x/y/z, focus_radius, target_radius, zero pad
   pair_word_type   req_tdata  = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   // contact_time, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // hit, outcome
   logic [RSP_USER_W-1:0] rsp_tuser;

   swept_sphere_pair_contact_time_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser)
   );

   always #2 clock = ~clock;

   // shared state between stimulus, driver, receiver and scoreboard
   pair_word_type      pending_pairs[$];
   contact_result_type expected_contacts[$];
   logic [TOLW-1:0] tolerance_copy = 16'd4;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   int unsigned     hold_requests = 0;
   int unsigned     hold_served   = 0;
   int unsigned     hold_left     = 0;
   int unsigned     mismatch_count = 0;
   int unsigned     outcome_seen[6];
   int unsigned     quiet_cycles = 0;
   int unsigned     pairs_sent = 0;

   // Integer square root, floor, of a 128-bit value.
   function automatic logic [63:0] floor_root(logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
   endfunction

   // Work out the earliest contact of one sphere pair under a given tolerance.
   function automatic contact_result_type predict_contact(pair_word_type pkt,
                                                          logic [TOLW-1:0] tol);
      longint      d[3];
      longint      v[3];
      longint      p;
      logic [63:0] vsq, dsq, pos, neg, rsum, rsq, babs, m, reach, num, tq, tol_sq;
      logic [127:0] b2, ac;
      contact_result_type r;
      vsq = 0; dsq = 0; pos = 0; neg = 0; tq = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($signed(pkt[i*CW +: CW]));
         v[i] = longint'($signed(pkt[(3+i)*CW +: CW]));
      end
      for (int i = 0; i < 3; i++) begin
         p = d[i] * v[i];
         vsq += v[i] * v[i];
         dsq += d[i] * d[i];
         if (p >= 0) pos += p;
         else neg += -p;
      end
      rsum   = {42'd0, pkt[6*CW +: RW]} + {42'd0, pkt[6*CW+RW +: RW]};
      rsq    = rsum * rsum;
      tol_sq = {48'd0, tol} * {48'd0, tol};
      r.hit = 1'b0;
      r.contact_time = '0;
      if (vsq <= tol_sq) r.outcome = OUT_NO_MOTION;
      else if (dsq <= rsq) r.outcome = OUT_OVERLAP;
      else if (pos >= neg) r.outcome = OUT_SEPARATE;
      else begin
         babs  = neg - pos;
         m     = floor_root({64'd0, vsq});
         reach = rsum + m;
         if ({64'd0, dsq} > {64'd0, reach} * {64'd0, reach}) r.outcome = OUT_UNREACH;
         else begin
            b2 = {64'd0, babs} * {64'd0, babs};
            ac = {64'd0, vsq} * {64'd0, dsq - rsq};
            if (ac > b2) r.outcome = OUT_MISS;
            else begin
               num = babs - floor_root(b2 - ac);
               if (num >= vsq) tq = 64'd1 << TIME_FRAC_BITS;
               else tq = 64'(({64'd0, num} << TIME_FRAC_BITS) / {64'd0, vsq});
               r.outcome = OUT_HIT;
               r.hit = 1'b1;
               r.contact_time = tq[TW-1:0];
            end
         end
      end
      return r;
   endfunction

   function automatic pair_word_type pack_pair(longint dx, longint dy, longint dz,
                                               longint vx, longint vy, longint vz,
                                               longint rf, longint rt);
      pair_word_type w;
      w = '0;
      w[0*CW +: CW] = dx[CW-1:0];
      w[1*CW +: CW] = dy[CW-1:0];
      w[2*CW +: CW] = dz[CW-1:0];
      w[3*CW +: CW] = vx[CW-1:0];
      w[4*CW +: CW] = vy[CW-1:0];
      w[5*CW +: CW] = vz[CW-1:0];
      w[6*CW +: RW] = rf[RW-1:0];
      w[6*CW+RW +: RW] = rt[RW-1:0];
      return w;
   endfunction

   // Mostly aim pairs at each other so that the deep stages see real work;
   // the rest is raw noise across every field bit, with the pad kept at zero.
   function automatic pair_word_type random_pair();
      pair_word_type w;
      longint   mag, f;
      longint   d[3];
      longint   v[3];
      if ($urandom_range(99) < 15) begin
         for (int i = 0; i < 6; i++) w[i*CW +: CW] = CW'($urandom);
         w[6*CW +: 2*RW] = {RW'($urandom), RW'($urandom)};
         w[REQ_DATA_W-1:6*CW+2*RW] = '0;
         return w;
      end
      mag = longint'(1) << $urandom_range(4, 21);
      f   = $urandom_range(1, 20);
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($urandom_range(0, 2*mag)) - mag;
         v[i] = -(d[i] * f) / 8 + longint'($urandom_range(0, mag/4)) - mag/8;
      end
      return pack_pair(d[0], d[1], d[2], v[0], v[1], v[2],
                       $urandom_range(0, mag/2), $urandom_range(0, mag/2));
   endfunction

   // Driver: offer pending pairs, record the prediction on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_contacts.push_back(predict_contact(req_tdata, tolerance_copy));
            pairs_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_pairs.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random backpressure, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Scoreboard: compare each result with the oldest prediction.
   always @(posedge clock) begin
      contact_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_contacts.size() == 0) begin
            $error("unexpected result transaction: tdata=%h tuser=%h", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_contacts.pop_front();
            if (rsp_tuser[0] !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tdata[TW-1:0] !== want.contact_time) begin
               $error("contact_time: expected %0d, actual %0d",
                      want.contact_time, rsp_tdata[TW-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser[3:1] !== want.outcome) begin
               $error("outcome: expected %0d, actual %0d", want.outcome, rsp_tuser[3:1]);
               mismatch_count++;
            end
            outcome_seen[want.outcome]++;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("** swept_sphere_pair_contact_time_core: FAILED **");
         $finish;
      end
   end

   // Wait until every offered pair has come back, then let the pipe drain.
   task automatic drain_pipeline();
      do @(posedge clock);
      while (pending_pairs.size() > 0 || req_tvalid || expected_contacts.size() > 0);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOLW-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      tolerance_copy    = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(int unsigned count);
      repeat (count) pending_pairs.push_back(random_pair());
      drain_pipeline();
   endtask

   localparam longint ONE = 4096;  // 1.0 in Q12.12

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed pairs under the reset tolerance; sender 38%, receiver 86%
      send_idle_pct = 38;
      recv_idle_pct = 86;
      pending_pairs.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(pack_pair(10*ONE, 0, 0, -20*ONE, 0, 0, ONE, ONE));
      pending_pairs.push_back(pack_pair(ONE, 0, 0, ONE, 0, 0, ONE, ONE));
      pending_pairs.push_back(pack_pair(10*ONE, 0, 0, ONE, 0, 0, ONE, ONE));
      pending_pairs.push_back(pack_pair(100*ONE, 0, 0, -ONE, 0, 0, ONE, ONE));
      pending_pairs.push_back(pack_pair(10*ONE, 5*ONE, 0, -20*ONE, 0, 0, ONE, ONE));
      pending_pairs.push_back(pack_pair(8*ONE, 0, 0, -6*ONE, 0, 0, ONE, ONE));
      pending_pairs.push_back(pack_pair(8*ONE, 0, 0, -3*ONE, 0, 0, ONE, ONE));
      pending_pairs.push_back(pack_pair(2*ONE+1, 0, 0, -8*ONE, 0, 0, ONE, ONE));
      pending_pairs.push_back(pack_pair(0, 0, 0, 4, 0, 0, 0, 0));
      pending_pairs.push_back(pack_pair(ONE, 0, 0, -5, 0, 0, 0, 0));
      pending_pairs.push_back(pack_pair(8388607, 8388607, 8388607,
                                        8388607, 8388607, 8388607, 4194303, 4194303));
      pending_pairs.push_back(pack_pair(-8388608, -8388608, -8388608,
                                        -8388608, -8388608, -8388608, 0, 0));
      pending_pairs.push_back(pack_pair(8388607, -8388608, 8388607,
                                        -8388608, 8388607, -8388608, 0, 4194303));
      pending_pairs.push_back(pack_pair(8388607, 8388607, 8388607,
                                        -8388608, -8388608, -8388608, 4194303, 4194303));
      pending_pairs.push_back(pack_pair(8388607, 0, 0, -8388608, 0, 0, 4194303, 0));
      pending_pairs.push_back(pack_pair(-8388608, 0, 0, 8388607, 0, 0, 0, 4194303));
      pending_pairs.push_back(pack_pair(0, 0, -300*ONE, 3, 7, 2000*ONE, 50*ONE, 0));
      drain_pipeline();

      // zero tolerance; hold the receiver off while the sender keeps offering
      write_tolerance(16'd0);
      hold_requests++;
      run_random(130);

      // widest tolerance, roles swapped
      write_tolerance(16'hFFFF);
      send_idle_pct = 86;
      recv_idle_pct = 38;
      run_random(130);

      // random tolerance, full rate both sides
      write_tolerance(TOLW'($urandom_range(1, 65534)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(140);

      $display("covered %0d pairs over 4 tolerance settings", pairs_sent);
      $display("outcomes hit/none/overlap/separate/unreach/miss: %0d/%0d/%0d/%0d/%0d/%0d",
               outcome_seen[0], outcome_seen[1], outcome_seen[2],
               outcome_seen[3], outcome_seen[4], outcome_seen[5]);
      if (mismatch_count == 0)
         $display("** swept_sphere_pair_contact_time_core: PASSED **");
      else
         $display("** swept_sphere_pair_contact_time_core: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
